// ===== rtl/fbpct_pkg.sv =====
// Package for the five-bit to prefix-code transcoder: tables, microcode and decode helper.
package fbpct_pkg;

    // Alphabet; the index of a character is its five-bit symbol.
    localparam logic [7:0] ALPHABET [32] = '{
        8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48,
        8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50,
        8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58,
        8'h59, 8'h5A, 8'h20, 8'h2E, 8'h2C, 8'h2D, 8'h27, 8'h3F
    };

    // Prefix code per symbol: length in bits and value, MSB first.
    localparam logic [3:0] CW_LEN [32] = '{
        4'd6, 4'd8, 4'd4, 4'd4, 4'd3, 4'd5, 4'd8, 4'd6,
        4'd4, 4'd8, 4'd4, 4'd5, 4'd8, 4'd8, 4'd5, 4'd3,
        4'd8, 4'd4, 4'd5, 4'd5, 4'd8, 4'd8, 4'd6, 4'd8,
        4'd8, 4'd8, 4'd3, 4'd6, 4'd6, 4'd8, 4'd6, 4'd6
    };
    localparam logic [7:0] CW_VAL [32] = '{
        8'h25, 8'h9A, 8'h05, 8'h01, 8'h06, 8'h09, 8'h9B, 8'h10,
        8'h07, 8'h98, 8'h06, 8'h04, 8'h99, 8'h9E, 8'h05, 8'h07,
        8'h9F, 8'h08, 8'h06, 8'h07, 8'h9C, 8'h9D, 8'h02, 8'h92,
        8'h93, 8'h90, 8'h05, 8'h11, 8'h03, 8'h91, 8'h00, 8'h01
    };

    localparam int BUF_W = 12;
    localparam int MIN_CW = 3;
    localparam int MAX_CW = 8;

    typedef logic [1:0] t_upc;
    localparam t_upc UPC_FETCH  = 2'd0;
    localparam t_upc UPC_DECODE = 2'd1;
    localparam t_upc UPC_EOL    = 2'd2;

    // What a step waits for before it executes.
    typedef enum logic [1:0] {
        GATE_IN,          // input transfer
        GATE_OUT_IF_HIT,  // output slot, only when a codeword is ready
        GATE_OUT          // output slot
    } t_gate;

    typedef enum logic [1:0] {
        DP_APPEND,
        DP_EMIT_SYM,
        DP_EMIT_EOL
    } t_dp_op;

    typedef enum logic [1:0] {
        COND_EOL,
        COND_MORE,
        COND_ALWAYS
    } t_cond;

    typedef struct packed {
        t_gate  gate;
        t_dp_op op;
        t_cond  cond;
        t_upc   tgt_t;
        t_upc   tgt_f;
    } t_uword;

    typedef struct packed {
        logic       hit;
        logic [4:0] sym;
        logic [3:0] len;
    } t_dec;

    typedef struct packed {
        logic       hit;
        logic [4:0] idx;
    } t_sym;

    function automatic t_uword ucode_rom(input t_upc pc);
        t_uword w;
        unique case (pc)
            UPC_FETCH:  w = '{GATE_IN,         DP_APPEND,   COND_EOL,    UPC_EOL,    UPC_DECODE};
            UPC_DECODE: w = '{GATE_OUT_IF_HIT, DP_EMIT_SYM, COND_MORE,   UPC_DECODE, UPC_FETCH};
            UPC_EOL:    w = '{GATE_OUT,        DP_EMIT_EOL, COND_ALWAYS, UPC_FETCH,  UPC_FETCH};
            default:    w = '{GATE_OUT,        DP_EMIT_EOL, COND_ALWAYS, UPC_FETCH,  UPC_FETCH};
        endcase
        return w;
    endfunction

    function automatic t_sym sym_index(input logic [7:0] ch);
        t_sym s;
        s = '0;
        for (int k = 0; k < 32; k++) begin
            if (ALPHABET[k] == ch) begin
                s.hit = 1'b1;
                s.idx = 5'(k);
            end
        end
        return s;
    endfunction

    // Oldest complete codeword at the head of the buffer, shortest length first.
    function automatic t_dec decode_head(input logic [BUF_W-1:0] buf_v,
                                         input logic [3:0] cnt_v);
        t_dec d;
        logic [BUF_W-1:0] head;
        logic [3:0] sh;
        d = '0;
        for (int len = MIN_CW; len <= MAX_CW; len++) begin
            if (!d.hit && cnt_v >= 4'(len)) begin
                sh = cnt_v - 4'(len);
                head = (buf_v >> sh) & ((BUF_W'(1) << len) - BUF_W'(1));
                for (int k = 0; k < 32; k++) begin
                    if (CW_LEN[k] == 4'(len) && BUF_W'(CW_VAL[k]) == head) begin
                        d.hit = 1'b1;
                        d.sym = 5'(k);
                        d.len = 4'(len);
                    end
                end
            end
        end
        return d;
    endfunction

endpackage

// ===== rtl/five_bit_to_prefix_code_transcoder_core.sv =====
// Five-bit to prefix-code transcoder core: microcoded sequencer and bit-buffer datapath.
//
// Each input transfer carries one ASCII character (tdata) or an end-of-line mark
// (tlast). An alphabet character (A-Z, space . , - ' ?) appends its 5-bit index to
// a 12-bit buffer; other characters are dropped. The buffer is then drained of
// complete prefix codewords (3..8 bits), one decoded letter per output transfer,
// at most four per character; tlast flags the final letter of that character.
// End of line drops leftover bits and gives one line-break transfer (tuser[1]).
// Timing: a three-step microprogram. Fetch takes one input transfer, then the
// decode step runs once per letter (waiting while the output is stalled), or
// once when the character completes no codeword. tready is high only in fetch,
// so a new character is not taken until the last one is drained. The decode
// and end-of-line steps load the single output register.
module five_bit_to_prefix_code_transcoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] char_code
    input  logic       i_s_tlast,   // end_of_line
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] letter
    output logic [1:0] o_m_tuser,   // [0] letter_valid, [1] line_break
    output logic       o_m_tlast    // last result of this input transfer
);
    import fbpct_pkg::*;

    t_upc             r_upc;
    logic [BUF_W-1:0] r_buf;
    logic [3:0]       r_cnt;
    logic [1:0]       r_n;       // letters already sent for this character
    logic             r_m_tvalid;
    logic [7:0]       r_m_tdata;
    logic [1:0]       r_m_tuser;
    logic             r_m_tlast;

    t_uword           uw;
    t_dec             cur_dec;
    t_dec             nxt_dec;
    t_sym             in_sym;
    logic [3:0]       rem_cnt;
    logic [BUF_W-1:0] rem_buf;
    logic             out_free;
    logic             gate_ok;
    logic             cond_ok;
    logic             more;
    logic             load_out;

    assign uw       = ucode_rom(r_upc);
    assign in_sym   = sym_index(i_s_tdata);
    assign cur_dec  = decode_head(r_buf, r_cnt);

    // Buffer after taking the head codeword; used to look ahead for tlast.
    assign rem_cnt  = r_cnt - cur_dec.len;
    assign rem_buf  = r_buf & ~({BUF_W{1'b1}} << rem_cnt);
    assign nxt_dec  = decode_head(rem_buf, rem_cnt);

    assign out_free = !r_m_tvalid || i_m_tready;
    assign more     = cur_dec.hit && nxt_dec.hit && (r_n != 2'd3);

    // Output register gets a new result this cycle.
    assign load_out = gate_ok && ((uw.op == DP_EMIT_EOL)
                                  || (uw.op == DP_EMIT_SYM && cur_dec.hit));

    always_comb begin
        unique case (uw.gate)
            GATE_IN:         gate_ok = i_s_tvalid;
            GATE_OUT_IF_HIT: gate_ok = !cur_dec.hit || out_free;
            GATE_OUT:        gate_ok = out_free;
            default:         gate_ok = 1'b0;
        endcase
    end

    always_comb begin
        unique case (uw.cond)
            COND_EOL:    cond_ok = i_s_tlast;
            COND_MORE:   cond_ok = more;
            COND_ALWAYS: cond_ok = 1'b1;
            default:     cond_ok = 1'b1;
        endcase
    end

    assign o_s_tready = (uw.gate == GATE_IN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc      <= UPC_FETCH;
            r_buf      <= '0;
            r_cnt      <= '0;
            r_n        <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (r_m_tvalid && i_m_tready && !load_out) begin
                r_m_tvalid <= 1'b0;
            end
            if (gate_ok) begin
                r_upc <= cond_ok ? uw.tgt_t : uw.tgt_f;
                unique case (uw.op)
                    DP_APPEND: begin
                        r_n <= '0;
                        if (!i_s_tlast && in_sym.hit) begin
                            if (r_cnt > 4'd7) begin
                                r_buf <= {{(BUF_W-5){1'b0}}, in_sym.idx};
                                r_cnt <= 4'd5;
                            end else begin
                                r_buf <= {r_buf[BUF_W-6:0], in_sym.idx};
                                r_cnt <= r_cnt + 4'd5;
                            end
                        end
                    end
                    DP_EMIT_SYM: begin
                        if (cur_dec.hit) begin
                            r_m_tvalid <= 1'b1;
                            r_m_tdata  <= ALPHABET[cur_dec.sym];
                            r_m_tuser  <= 2'b01;
                            r_m_tlast  <= !more;
                            r_buf      <= rem_buf;
                            r_cnt      <= rem_cnt;
                            r_n        <= r_n + 2'd1;
                        end
                    end
                    DP_EMIT_EOL: begin
                        r_m_tvalid <= 1'b1;
                        r_m_tdata  <= '0;
                        r_m_tuser  <= 2'b10;
                        r_m_tlast  <= 1'b1;
                        r_buf      <= '0;
                        r_cnt      <= '0;
                    end
                    default: begin
                        r_buf <= r_buf;
                    end
                endcase
            end
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;
    assign o_m_tlast  = r_m_tlast;

    // Buffer never overfills.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 4'd12)
        else $error("bit count above buffer size");

    // Waiting for a character means no complete codeword is left in the buffer.
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == UPC_FETCH) |-> (!cur_dec.hit && r_cnt <= 4'd7))
        else $error("complete codeword left pending at fetch");

    // A line-break transfer carries no letter and closes its item.
    a_eol_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_tvalid && r_m_tuser[1]) |-> (r_m_tlast && r_m_tdata == 8'd0 && !r_m_tuser[0]))
        else $error("malformed line-break result");

    // Output register is only reloaded once its previous transfer is taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_tvalid && !i_m_tready) |=> (r_m_tvalid && $stable(r_m_tdata)
                                          && $stable(r_m_tuser) && $stable(r_m_tlast)))
        else $error("pending result overwritten");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the transcoder core: predicts decoded letters and line breaks.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One expected output transfer, same field order as the master side.
    typedef struct packed {
        logic [7:0] letter;
        logic       letter_valid;
        logic       line_break;
        logic       last;
    } t_decoded;

    // Receiver stall patterns.
    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_SPARSE,
        RX_PERIODIC
    } t_rx_mode;

    // Symbol k is the k-th character from the left.
    localparam logic [8*32-1:0] ALPHABET_STR = "ABCDEFGHIJKLMNOPQRSTUVWXYZ .,-'?";
    localparam int HOLD_CYCLES  = 80;   // long receiver hold-off
    localparam int TAIL_CYCLES  = 16;   // settle time after the last expected transfer
    localparam int RANDOM_ITEMS = 140;

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tready = 1'b0;
    wire        s_tready;
    wire        m_tvalid;
    wire  [7:0] m_tdata;
    wire  [1:0] m_tuser;
    wire        m_tlast;

    // Predictor state: pending code bits, oldest bit at position pend_count-1.
    logic [11:0] pend_bits  = '0;
    logic [3:0]  pend_count = '0;
    t_decoded    letters_due[$];

    int       fail_count  = 0;
    int       items_taken = 0;   // transfers that are not simply dropped
    bit       gaps_on     = 1'b0;
    int       burst_left  = 0;
    t_rx_mode rx_mode     = RX_ALWAYS;
    int       hold_ticket = 0;   // bumped by the stimulus to request a hold-off
    int       hold_served = 0;
    int       hold_left   = 0;
    int       period_cnt  = 0;

    five_bit_to_prefix_code_transcoder_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),    // [7:0] char_code
        .i_s_tlast  (s_tlast),    // end_of_line
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),    // [7:0] letter
        .o_m_tuser  (m_tuser),    // [0] letter_valid, [1] line_break
        .o_m_tlast  (m_tlast)     // last result of this input transfer
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [7:0] letter_of(input int sym);
        return ALPHABET_STR[8*(31-sym) +: 8];
    endfunction

    // Prefix code of a symbol as {length, value}; value right-aligned, sent MSB first.
    function automatic logic [11:0] codeword_of(input logic [4:0] sym);
        case (sym)
            5'd0:  return {4'd6, 8'h25};   // A
            5'd1:  return {4'd8, 8'h9A};   // B
            5'd2:  return {4'd4, 8'h05};   // C
            5'd3:  return {4'd4, 8'h01};   // D
            5'd4:  return {4'd3, 8'h06};   // E
            5'd5:  return {4'd5, 8'h09};   // F
            5'd6:  return {4'd8, 8'h9B};   // G
            5'd7:  return {4'd6, 8'h10};   // H
            5'd8:  return {4'd4, 8'h07};   // I
            5'd9:  return {4'd8, 8'h98};   // J
            5'd10: return {4'd4, 8'h06};   // K
            5'd11: return {4'd5, 8'h04};   // L
            5'd12: return {4'd8, 8'h99};   // M
            5'd13: return {4'd8, 8'h9E};   // N
            5'd14: return {4'd5, 8'h05};   // O
            5'd15: return {4'd3, 8'h07};   // P
            5'd16: return {4'd8, 8'h9F};   // Q
            5'd17: return {4'd4, 8'h08};   // R
            5'd18: return {4'd5, 8'h06};   // S
            5'd19: return {4'd5, 8'h07};   // T
            5'd20: return {4'd8, 8'h9C};   // U
            5'd21: return {4'd8, 8'h9D};   // V
            5'd22: return {4'd6, 8'h02};   // W
            5'd23: return {4'd8, 8'h92};   // X
            5'd24: return {4'd8, 8'h93};   // Y
            5'd25: return {4'd8, 8'h90};   // Z
            5'd26: return {4'd3, 8'h05};   // space
            5'd27: return {4'd6, 8'h11};   // period
            5'd28: return {4'd6, 8'h03};   // comma
            5'd29: return {4'd8, 8'h91};   // hyphen
            5'd30: return {4'd6, 8'h00};   // apostrophe
            default: return {4'd6, 8'h01}; // question mark
        endcase
    endfunction

    // Advance the predictor by one accepted input transfer and queue the letters
    // (or the line break) it must produce. used=0 for a dropped character.
    task automatic transcode_char(input logic [7:0] ch, input logic eol, output bit used);
        int          idx;
        int          k;
        int          len;
        int          hit_sym;
        int          hit_len;
        int          produced;
        logic [11:0] head;
        logic [11:0] cw;
        t_decoded    r;
        used = 1'b1;
        if (eol) begin
            // leftover bits are dropped, one line-break transfer
            pend_bits  = '0;
            pend_count = '0;
            r = {8'h00, 1'b0, 1'b1, 1'b1};
            letters_due.push_back(r);
        end else begin
            idx = -1;
            for (k = 0; k < 32; k++) begin
                if (letter_of(k) == ch) idx = k;
            end
            if (idx < 0) begin
                used = 1'b0;
            end else begin
                if (pend_count > 4'd7) begin
                    pend_bits  = '0;
                    pend_count = '0;
                end
                pend_bits  = {pend_bits[6:0], idx[4:0]};
                pend_count = pend_count + 4'd5;
                produced = 0;
                hit_sym  = 0;
                hit_len  = 0;
                // greedy: shortest complete codeword at the head, up to four per char
                while (produced < 4 && hit_sym >= 0) begin
                    hit_sym = -1;
                    for (len = 3; len <= 8 && hit_sym < 0 && len <= pend_count; len++) begin
                        head = (pend_bits >> (pend_count - len)) & ((12'd1 << len) - 12'd1);
                        for (k = 0; k < 32; k++) begin
                            cw = codeword_of(k[4:0]);
                            if (cw[11:8] == len && cw[7:0] == head[7:0]) begin
                                hit_sym = k;
                                hit_len = len;
                            end
                        end
                    end
                    if (hit_sym >= 0) begin
                        pend_count = pend_count - 4'(hit_len);
                        pend_bits  = pend_bits & ((12'd1 << pend_count) - 12'd1);
                        r = {letter_of(hit_sym), 1'b1, 1'b0, 1'b0};
                        letters_due.push_back(r);
                        produced++;
                    end
                end
                if (produced > 0) begin
                    r = letters_due.pop_back();
                    r.last = 1'b1;
                    letters_due.push_back(r);
                end
            end
        end
    endtask

    // Offer one item and hold it until the transfer happens. Called on a rising
    // edge; valid stays high so a following call continues the burst without a
    // bubble. With gaps on, valid drops for a random gap when a burst runs out.
    task automatic send_item(input logic [7:0] ch, input logic eol);
        bit used;
        s_tdata  <= ch;
        s_tlast  <= eol;
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        transcode_char(ch, eol, used);
        if (used) items_taken++;
        if (gaps_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 11);
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    // Sender pause: stop offering until every predicted transfer has arrived.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (letters_due.size() != 0) @(posedge i_clk);
    endtask

    // Characters outside the alphabet: both extremes of char_code, lowercase,
    // and the bytes 0x7F and 0x80. None of them gives a transfer.
    task automatic test_outside_alphabet();
        gaps_on = 1'b0;
        rx_mode <= RX_ALWAYS;
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h61, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h7F, 1'b0);
    endtask

    // Empty line, a character that completes no codeword, end of line with
    // pending bits, and end of line carrying alphabet data that must be ignored.
    task automatic test_line_ends();
        send_item(8'h00, 1'b1);
        send_item("A", 1'b0);
        send_item(8'hFF, 1'b1);
        send_item("A", 1'b1);
    endtask

    // A short line that uses all the punctuation symbols, with random stalls.
    task automatic test_sentence();
        localparam logic [8*11-1:0] TEXT = "ZAP-'?. ,QW";
        int n;
        gaps_on = 1'b1;
        rx_mode <= RX_RANDOM;
        for (n = 10; n >= 0; n--) send_item(TEXT[8*n +: 8], 1'b0);
        send_item(8'h5A, 1'b1);
        wait_drained();
    endtask

    // Mostly well-formed lines of random alphabet text ending in end of line,
    // with some noise bytes and some lines left unterminated. Stall pattern and
    // idling change from line to line.
    task automatic test_random_lines();
        int goal;
        int line_len;
        int n;
        goal = items_taken + RANDOM_ITEMS;
        while (items_taken < goal) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            gaps_on = ($urandom_range(0, 3) != 0);
            line_len = $urandom_range(1, 24);
            for (n = 0; n < line_len; n++) begin
                if ($urandom_range(0, 7) == 0)
                    send_item(8'($urandom_range(0, 255)), 1'b0);
                else
                    send_item(letter_of($urandom_range(0, 31)), 1'b0);
            end
            if ($urandom_range(0, 7) != 0) send_item(8'($urandom), 1'b1);
            if ($urandom_range(0, 5) == 0) wait_drained();
        end
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering
    // back to back; the output register fills and input tready must drop.
    task automatic test_backpressure();
        int n;
        gaps_on = 1'b0;
        rx_mode <= RX_ALWAYS;
        hold_ticket <= hold_ticket + 1;
        for (n = 0; n < 24; n++) send_item(letter_of($urandom_range(0, 31)), 1'b0);
        send_item(8'($urandom), 1'b1);
        wait_drained();
    endtask

    // Receiver: hold-off requests take priority, otherwise the selected pattern.
    always @(posedge i_clk) begin
        period_cnt <= (period_cnt == 6) ? 0 : period_cnt + 1;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_ticket != hold_served) begin
            hold_served <= hold_ticket;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:   m_tready <= 1'b1;
                RX_RANDOM:   m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE:   m_tready <= ($urandom_range(0, 7) != 0);
                RX_PERIODIC: m_tready <= (period_cnt < 4);
                default:     m_tready <= 1'b1;
            endcase
        end
    end

    // Every output transfer is matched against the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_decoded exp_r;
        t_decoded got_r;
        if (i_rst_n && m_tvalid && m_tready) begin
            got_r = {m_tdata, m_tuser[0], m_tuser[1], m_tlast};
            if (letters_due.size() == 0) begin
                $display("%0t: extra transfer, expected none: letter=%h valid=%b brk=%b last=%b",
                         $time, got_r.letter, got_r.letter_valid, got_r.line_break, got_r.last);
                fail_count++;
            end else begin
                exp_r = letters_due.pop_front();
                if (got_r.letter !== exp_r.letter || got_r.letter_valid !== exp_r.letter_valid ||
                    got_r.line_break !== exp_r.line_break || got_r.last !== exp_r.last) begin
                    $display("%0t: mismatch: expected letter=%h valid=%b brk=%b last=%b",
                             $time, exp_r.letter, exp_r.letter_valid, exp_r.line_break,
                             exp_r.last);
                    $display("%0t:           actual   letter=%h valid=%b brk=%b last=%b",
                             $time, got_r.letter, got_r.letter_valid, got_r.line_break,
                             got_r.last);
                    fail_count++;
                end
            end
        end
    end

    initial begin : run_tests
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_outside_alphabet();
        test_line_ends();
        test_sentence();
        test_random_lines();
        test_backpressure();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** five_bit_to_prefix_code_transcoder_core: PASSED **");
        end else begin
            $display("** five_bit_to_prefix_code_transcoder_core: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #500_000;
        $display("** five_bit_to_prefix_code_transcoder_core: FAILED **");
        $finish;
    end

endmodule
